// ===== sv/i2cmra_pkg.sv =====
// Shared types and codes for the I2C master register access block.
package i2cmra_pkg;

  // Command codes carried by each input transaction
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_BYTE  = 2'd3;

  // Completion status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUS_BUSY = 2'd1;
  localparam logic [1:0] ST_BUS_ERR  = 2'd2;
  localparam logic [1:0] ST_NACK     = 2'd3;

  // Bits per byte on the bus
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Bus sequencer phases, one-hot
  typedef enum logic [15:0] {
    PH_IDLE       = 16'h0001,
    PH_START      = 16'h0002,
    PH_SEND_ADDR  = 16'h0004,
    PH_ACK_ADDR   = 16'h0008,
    PH_SEND_REG   = 16'h0010,
    PH_ACK_REG    = 16'h0020,
    PH_WAIT       = 16'h0040,
    PH_SEND_DATA  = 16'h0080,
    PH_ACK_DATA   = 16'h0100,
    PH_RSTART     = 16'h0200,
    PH_SEND_RADDR = 16'h0400,
    PH_ACK_RADDR  = 16'h0800,
    PH_RECV       = 16'h1000,
    PH_MACK       = 16'h2000,
    PH_STOP_OK    = 16'h4000,
    PH_STOP_NACK  = 16'h8000
  } phase_e;

endpackage

// ===== sv/i2c_master_register_access.sv =====
// I2C master register access: bus sequencer with registered input and result stages.
//
// Each input transaction is one bus delay interval (a tick) and yields exactly one
// result transaction carrying the SCL/SDA levels for that interval plus read data,
// write-byte request and completion status. The block takes one transaction per
// clock cycle while out_stall_i does not hold a result; the input register and
// the result register sit either side of the combinational sequencer update. A
// result held by out_stall_i blocks the input register, and in_stall_o rises as
// soon as that register holds a transaction. A write sends start, address,
// register byte and length data bytes, each requested through need_byte_o and
// supplied with the byte command; a read adds a repeated start and receives
// length bytes, reported on rd_valid_o/rd_byte_o.
module i2c_master_register_access (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [6:0] dev_addr_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] length_i,
  input  logic [7:0] wr_byte_i,
  input  logic       sda_in_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic [7:0] rd_byte_o,
  output logic       rd_valid_o,
  output logic       need_byte_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [1:0] status_o
);
  import i2cmra_pkg::*;

  // Input stage
  logic       in_valid_q;
  logic [1:0] cmd_q;
  logic [6:0] dev_addr_q;
  logic [7:0] reg_addr_q;
  logic [7:0] length_q;
  logic [7:0] wr_byte_q;
  logic       sda_in_q;

  // Sequencer state
  phase_e     phase_q, phase_d;
  logic [1:0] sub_q, sub_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] shift_q, shift_d;
  logic       is_read_q, is_read_d;
  logic [6:0] tgt_addr_q, tgt_addr_d;
  logic [7:0] tgt_reg_q, tgt_reg_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;

  // Per-tick results
  logic       rd_valid_d;
  logic [7:0] rd_byte_d;
  logic       need_d;
  logic       done_d;
  logic [1:0] status_d;

  // Result stage
  logic       out_valid_q;
  logic       scl_out_q, sda_out_q, rd_valid_q, need_q, busy_q, done_q;
  logic [7:0] rd_byte_q;
  logic [1:0] status_q;

  logic advance;
  logic in_take;

  // Handshake: the input register moves on whenever the result register is free
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Sequencer step for one tick
  always_comb begin
    phase_d      = phase_q;
    sub_d        = sub_q;
    bit_cnt_d    = bit_cnt_q;
    bytes_left_d = bytes_left_q;
    shift_d      = shift_q;
    is_read_d    = is_read_q;
    tgt_addr_d   = tgt_addr_q;
    tgt_reg_d    = tgt_reg_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    rd_valid_d   = 1'b0;
    rd_byte_d    = 8'h00;
    need_d       = 1'b0;
    done_d       = 1'b0;
    status_d     = ST_OK;

    // Command intake
    if (phase_q == PH_IDLE) begin
      if (cmd_q == CMD_WRITE || cmd_q == CMD_READ) begin
        tgt_addr_d   = dev_addr_q;
        tgt_reg_d    = reg_addr_q;
        bytes_left_d = length_q;
        is_read_d    = (cmd_q == CMD_READ);
        phase_d      = PH_START;
        sub_d        = 2'd0;
        bit_cnt_d    = 4'd0;
      end
    end else if (phase_q == PH_WAIT) begin
      if (cmd_q == CMD_BYTE) begin
        shift_d   = wr_byte_q;
        phase_d   = PH_SEND_DATA;
        sub_d     = 2'd0;
        bit_cnt_d = 4'd0;
      end else begin
        need_d = 1'b1;
      end
    end

    // Bus interval
    unique case (phase_d)
      PH_IDLE, PH_WAIT: begin
      end

      PH_START, PH_RSTART: begin
        if (sub_d == 2'd0) begin
          scl_d = 1'b1;
          sda_d = 1'b1;
          if (!sda_in_q) begin
            // line held low by another master
            sub_d = 2'd0;
            if (phase_d == PH_START) begin
              phase_d   = PH_IDLE;
              bit_cnt_d = 4'd0;
              done_d    = 1'b1;
              status_d  = ST_BUS_BUSY;
            end else begin
              phase_d   = PH_SEND_RADDR;
              bit_cnt_d = 4'd0;
              shift_d   = {tgt_addr_d, 1'b1};
            end
          end else begin
            sub_d = 2'd1;
          end
        end else if (sub_d == 2'd1) begin
          scl_d = 1'b1;
          sda_d = 1'b0;
          if (sda_in_q) begin
            // line failed to go low
            sub_d = 2'd0;
            if (phase_d == PH_START) begin
              phase_d   = PH_IDLE;
              bit_cnt_d = 4'd0;
              done_d    = 1'b1;
              status_d  = ST_BUS_ERR;
            end else begin
              phase_d   = PH_SEND_RADDR;
              bit_cnt_d = 4'd0;
              shift_d   = {tgt_addr_d, 1'b1};
            end
          end else begin
            sub_d = 2'd2;
          end
        end else begin
          sda_d     = 1'b0;
          sub_d     = 2'd0;
          bit_cnt_d = 4'd0;
          if (phase_d == PH_START) begin
            phase_d = PH_SEND_ADDR;
            shift_d = {tgt_addr_d, 1'b0};
          end else begin
            phase_d = PH_SEND_RADDR;
            shift_d = {tgt_addr_d, 1'b1};
          end
        end
      end

      PH_SEND_ADDR, PH_SEND_REG, PH_SEND_DATA, PH_SEND_RADDR: begin
        if (sub_d == 2'd0) begin
          scl_d = 1'b0;
        end else if (sub_d == 2'd1) begin
          sda_d = shift_d[7];
        end else begin
          scl_d = 1'b1;
        end
        if (sub_d < 2'd2) begin
          sub_d = sub_d + 2'd1;
        end else begin
          sub_d     = 2'd0;
          shift_d   = {shift_d[6:0], 1'b0};
          bit_cnt_d = bit_cnt_d + 4'd1;
          if (bit_cnt_d >= BITS_PER_BYTE) begin
            bit_cnt_d = 4'd0;
            shift_d   = 8'h00;
            case (phase_d)
              PH_SEND_ADDR: phase_d = PH_ACK_ADDR;
              PH_SEND_REG:  phase_d = PH_ACK_REG;
              PH_SEND_DATA: phase_d = PH_ACK_DATA;
              default:      phase_d = PH_ACK_RADDR;
            endcase
          end
        end
      end

      PH_ACK_ADDR, PH_ACK_REG, PH_ACK_DATA, PH_ACK_RADDR: begin
        if (sub_d == 2'd0) begin
          scl_d = 1'b0;
        end else if (sub_d == 2'd1) begin
          sda_d = 1'b1;
        end else if (sub_d == 2'd2) begin
          scl_d   = 1'b1;
          shift_d = {7'd0, sda_in_q};
        end else begin
          scl_d = 1'b0;
        end
        if (sub_d < 2'd3) begin
          sub_d = sub_d + 2'd1;
        end else begin
          sub_d     = 2'd0;
          bit_cnt_d = 4'd0;
          if (phase_d == PH_ACK_ADDR) begin
            if (shift_d[0]) begin
              phase_d = PH_STOP_NACK;
              shift_d = 8'h00;
            end else begin
              phase_d = PH_SEND_REG;
              shift_d = tgt_reg_d;
            end
          end else if (phase_d == PH_ACK_REG && is_read_d) begin
            phase_d = PH_RSTART;
            shift_d = 8'h00;
          end else if (phase_d == PH_ACK_RADDR) begin
            phase_d = (bytes_left_d == 8'd0) ? PH_STOP_OK : PH_RECV;
            shift_d = 8'h00;
          end else if (shift_d[0]) begin
            phase_d = PH_STOP_NACK;
            shift_d = 8'h00;
          end else begin
            // write register or data byte acknowledged
            if (phase_d == PH_ACK_DATA && bytes_left_d != 8'd0) begin
              bytes_left_d = bytes_left_d - 8'd1;
            end
            phase_d = (bytes_left_d == 8'd0) ? PH_STOP_OK : PH_WAIT;
            shift_d = 8'h00;
          end
        end
      end

      PH_RECV: begin
        sda_d = 1'b1;
        if (sub_d == 2'd0) begin
          scl_d = 1'b0;
          sub_d = 2'd1;
        end else begin
          scl_d     = 1'b1;
          sub_d     = 2'd0;
          shift_d   = {shift_d[6:0], sda_in_q};
          bit_cnt_d = bit_cnt_d + 4'd1;
          if (bit_cnt_d >= BITS_PER_BYTE) begin
            rd_valid_d = 1'b1;
            rd_byte_d  = shift_d;
            phase_d    = PH_MACK;
            bit_cnt_d  = 4'd0;
          end
        end
      end

      PH_MACK: begin
        // ACK each byte, NACK the last
        if (sub_d == 2'd0) begin
          scl_d = 1'b0;
        end else if (sub_d == 2'd1) begin
          sda_d = (bytes_left_d <= 8'd1);
        end else if (sub_d == 2'd2) begin
          scl_d = 1'b1;
        end else begin
          scl_d = 1'b0;
        end
        if (sub_d < 2'd3) begin
          sub_d = sub_d + 2'd1;
        end else begin
          if (bytes_left_d != 8'd0) begin
            bytes_left_d = bytes_left_d - 8'd1;
          end
          phase_d   = (bytes_left_d == 8'd0) ? PH_STOP_OK : PH_RECV;
          sub_d     = 2'd0;
          bit_cnt_d = 4'd0;
        end
      end

      PH_STOP_OK, PH_STOP_NACK: begin
        if (sub_d == 2'd0) begin
          scl_d = 1'b0;
        end else if (sub_d == 2'd1) begin
          sda_d = 1'b0;
        end else if (sub_d == 2'd2) begin
          scl_d = 1'b1;
        end else begin
          sda_d = 1'b1;
        end
        if (sub_d < 2'd3) begin
          sub_d = sub_d + 2'd1;
        end else begin
          status_d  = (phase_d == PH_STOP_NACK) ? ST_NACK : ST_OK;
          done_d    = 1'b1;
          phase_d   = PH_IDLE;
          sub_d     = 2'd0;
          bit_cnt_d = 4'd0;
        end
      end

      default: begin
        phase_d   = PH_IDLE;
        sub_d     = 2'd0;
        bit_cnt_d = 4'd0;
      end
    endcase
  end

  // Control and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_IDLE;
      sub_q        <= 2'd0;
      bit_cnt_q    <= 4'd0;
      bytes_left_q <= 8'd0;
      shift_q      <= 8'd0;
      is_read_q    <= 1'b0;
      tgt_addr_q   <= 7'd0;
      tgt_reg_q    <= 8'd0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q  <= 1'b1;
        phase_q      <= phase_d;
        sub_q        <= sub_d;
        bit_cnt_q    <= bit_cnt_d;
        bytes_left_q <= bytes_left_d;
        shift_q      <= shift_d;
        is_read_q    <= is_read_d;
        tgt_addr_q   <= tgt_addr_d;
        tgt_reg_q    <= tgt_reg_d;
        scl_q        <= scl_d;
        sda_q        <= sda_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q      <= cmd_i;
      dev_addr_q <= dev_addr_i;
      reg_addr_q <= reg_addr_i;
      length_q   <= length_i;
      wr_byte_q  <= wr_byte_i;
      sda_in_q   <= sda_in_i;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      scl_out_q  <= scl_d;
      sda_out_q  <= sda_d;
      rd_byte_q  <= rd_byte_d;
      rd_valid_q <= rd_valid_d;
      need_q     <= need_d;
      busy_q     <= (phase_d != PH_IDLE);
      done_q     <= done_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = scl_out_q;
  assign sda_out_o   = sda_out_q;
  assign rd_byte_o   = rd_byte_q;
  assign rd_valid_o  = rd_valid_q;
  assign need_byte_o = need_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign status_o    = status_q;

endmodule

// ===== tb/tb_i2c_master_register_access.sv =====
// Self-checking testbench for the I2C master register access block.
`timescale 1ns / 1ps

module tb_i2c_master_register_access;
  import i2cmra_pkg::*;

  // One input transaction: a single bus delay interval
  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] dev;
    logic [7:0] reg_a;
    logic [7:0] len;
    logic [7:0] wrb;
    logic       sda;
  } bus_item_t;

  // One result transaction, in port order
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       need;
    logic       busy;
    logic       done;
    logic [1:0] status;
  } bus_res_t;

  typedef struct packed {
    bus_item_t item;
    logic      typed;
    bus_res_t  res;
  } dir_row_t;

  // Outcome of one start-condition interval
  typedef enum logic [1:0] {SC_RUN, SC_OK, SC_BUSY, SC_ERR} start_e;

  localparam int BUS_TICKS = 800;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] cmd_i;
  logic [6:0] dev_addr_i;
  logic [7:0] reg_addr_i;
  logic [7:0] length_i;
  logic [7:0] wr_byte_i;
  logic       sda_in_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       scl_out_o;
  logic       sda_out_o;
  logic [7:0] rd_byte_o;
  logic       rd_valid_o;
  logic       need_byte_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [1:0] status_o;

  i2c_master_register_access dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .dev_addr_i  (dev_addr_i),
    .reg_addr_i  (reg_addr_i),
    .length_i    (length_i),
    .wr_byte_i   (wr_byte_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .rd_byte_o   (rd_byte_o),
    .rd_valid_o  (rd_valid_o),
    .need_byte_o (need_byte_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .status_o    (status_o)
  );

  // Sequencer copy kept by the testbench
  phase_e     bus_ph;
  logic [1:0] step;
  logic [3:0] nbit;
  logic [7:0] left_cnt;
  logic [7:0] shift_q;
  logic       rd_mode;
  logic [6:0] tgt_addr;
  logic [7:0] tgt_reg;
  logic       scl_q;
  logic       sda_q;

  // Stimulus plan for the transfer under way
  logic       plan_nack_addr;

  bus_res_t   pending_res_q[$];
  dir_row_t   dir_tab[$];
  int         burst_left;
  int         n_items;
  int         n_ticks;
  int         n_checked;
  int         n_err;
  int         n_rd;
  int         n_end[4];
  int         stall_cyc;
  int         stall_mode;

  function automatic void enter(phase_e p);
    bus_ph = p;
    step   = '0;
    nbit   = '0;
  endfunction

  // One interval of a start or repeated start condition
  function automatic start_e start_cond(logic sda);
    start_e r;
    r = SC_RUN;
    case (step)
      2'd0: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        if (!sda) r = SC_BUSY;
      end
      2'd1: begin
        scl_q = 1'b1;
        sda_q = 1'b0;
        if (sda) r = SC_ERR;
      end
      default: begin
        sda_q = 1'b0;
        r = SC_OK;
      end
    endcase
    if (r == SC_RUN) step = step + 2'd1;
    else step = '0;
    return r;
  endfunction

  // Advance the sequencer copy by one interval and return the bus result
  function automatic bus_res_t bus_step(bus_item_t it);
    bus_res_t r;
    start_e   sc;
    logic     nack;
    r = '0;
    if (bus_ph == PH_IDLE) begin
      if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
        tgt_addr = it.dev;
        tgt_reg  = it.reg_a;
        left_cnt = it.len;
        rd_mode  = (it.cmd == CMD_READ);
        enter(PH_START);
      end
    end else if (bus_ph == PH_WAIT) begin
      if (it.cmd == CMD_BYTE) begin
        shift_q = it.wrb;
        enter(PH_SEND_DATA);
      end else begin
        r.need = 1'b1;
      end
    end

    case (bus_ph)
      PH_START: begin
        sc = start_cond(it.sda);
        if (sc == SC_OK) begin
          enter(PH_SEND_ADDR);
          shift_q = {tgt_addr, 1'b0};
        end else if (sc != SC_RUN) begin
          enter(PH_IDLE);
          r.done   = 1'b1;
          r.status = (sc == SC_BUSY) ? ST_BUS_BUSY : ST_BUS_ERR;
        end
      end
      // a failed repeated start is ignored, the read address follows at once
      PH_RSTART: begin
        if (start_cond(it.sda) != SC_RUN) begin
          enter(PH_SEND_RADDR);
          shift_q = {tgt_addr, 1'b1};
        end
      end
      PH_SEND_ADDR, PH_SEND_REG, PH_SEND_DATA, PH_SEND_RADDR: begin
        case (step)
          2'd0:    scl_q = 1'b0;
          2'd1:    sda_q = shift_q[7];
          default: scl_q = 1'b1;
        endcase
        if (step < 2'd2) begin
          step = step + 2'd1;
        end else begin
          step    = '0;
          shift_q = shift_q << 1;
          nbit    = nbit + 4'd1;
          if (nbit >= BITS_PER_BYTE) begin
            nbit    = '0;
            shift_q = '0;
            bus_ph  = phase_e'(bus_ph << 1);
          end
        end
      end
      PH_ACK_ADDR, PH_ACK_REG, PH_ACK_DATA, PH_ACK_RADDR: begin
        case (step)
          2'd0: scl_q = 1'b0;
          2'd1: sda_q = 1'b1;
          2'd2: begin
            scl_q   = 1'b1;
            shift_q = {7'd0, it.sda};
          end
          default: scl_q = 1'b0;
        endcase
        if (step < 2'd3) begin
          step = step + 2'd1;
        end else begin
          step    = '0;
          nack    = shift_q[0];
          shift_q = '0;
          if (bus_ph == PH_ACK_ADDR) begin
            if (nack) begin
              enter(PH_STOP_NACK);
            end else begin
              enter(PH_SEND_REG);
              shift_q = tgt_reg;
            end
          end else if (bus_ph == PH_ACK_REG && rd_mode) begin
            enter(PH_RSTART);
          end else if (bus_ph == PH_ACK_RADDR) begin
            if (left_cnt == 8'd0) enter(PH_STOP_OK);
            else enter(PH_RECV);
          end else if (nack) begin
            enter(PH_STOP_NACK);
          end else begin
            if (bus_ph == PH_ACK_DATA && left_cnt > 8'd0) left_cnt = left_cnt - 8'd1;
            if (left_cnt == 8'd0) enter(PH_STOP_OK);
            else enter(PH_WAIT);
          end
        end
      end
      PH_RECV: begin
        sda_q = 1'b1;
        if (step == 2'd0) begin
          scl_q = 1'b0;
          step  = 2'd1;
        end else begin
          scl_q   = 1'b1;
          step    = '0;
          shift_q = {shift_q[6:0], it.sda};
          nbit    = nbit + 4'd1;
          if (nbit >= BITS_PER_BYTE) begin
            r.rd_valid = 1'b1;
            r.rd_byte  = shift_q;
            enter(PH_MACK);
          end
        end
      end
      // master ACK, NACK on the last byte
      PH_MACK: begin
        case (step)
          2'd0:    scl_q = 1'b0;
          2'd1:    sda_q = (left_cnt <= 8'd1);
          2'd2:    scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
        if (step < 2'd3) begin
          step = step + 2'd1;
        end else begin
          if (left_cnt > 8'd0) left_cnt = left_cnt - 8'd1;
          if (left_cnt == 8'd0) enter(PH_STOP_OK);
          else enter(PH_RECV);
        end
      end
      PH_STOP_OK, PH_STOP_NACK: begin
        case (step)
          2'd0:    scl_q = 1'b0;
          2'd1:    sda_q = 1'b0;
          2'd2:    scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
        if (step < 2'd3) begin
          step = step + 2'd1;
        end else begin
          r.status = (bus_ph == PH_STOP_NACK) ? ST_NACK : ST_OK;
          r.done   = 1'b1;
          enter(PH_IDLE);
        end
      end
      PH_IDLE, PH_WAIT: ;
      default: enter(PH_IDLE);
    endcase

    r.scl  = scl_q;
    r.sda  = sda_q;
    r.busy = (bus_ph != PH_IDLE);
    return r;
  endfunction

  // Choose the next interval so that most transfers run well-formed
  function automatic bus_item_t pick_bus_item();
    bus_item_t it;
    int        roll;
    it.cmd   = CMD_TICK;
    it.dev   = 7'($urandom);
    it.reg_a = 8'($urandom);
    it.len   = 8'($urandom);
    it.wrb   = 8'($urandom);
    it.sda   = 1'($urandom);
    roll     = $urandom_range(0, 99);
    case (bus_ph)
      PH_IDLE: begin
        if (roll < 85) begin
          it.cmd = (roll < 45) ? CMD_WRITE : CMD_READ;
          it.sda = 1'b1;
          plan_nack_addr = ($urandom_range(0, 9) == 0);
          roll = $urandom_range(0, 99);
          if (roll < 75) begin
            it.len = 8'($urandom_range(0, 3));
          end else if (roll < 93) begin
            it.len = 8'($urandom_range(4, 8));
          end else begin
            // long transfer, cut short by an address NACK
            plan_nack_addr = 1'b1;
          end
        end else begin
          it.cmd = (roll < 92) ? CMD_TICK : CMD_BYTE;
        end
      end
      PH_WAIT: begin
        if (roll < 85) it.cmd = CMD_BYTE;
        else it.cmd = 2'($urandom_range(0, 2));
      end
      PH_START, PH_RSTART: it.sda = (step == 2'd0);
      PH_ACK_ADDR: if (step == 2'd2) it.sda = plan_nack_addr;
      PH_ACK_REG, PH_ACK_DATA, PH_ACK_RADDR: begin
        if (step == 2'd2) it.sda = ($urandom_range(0, 19) == 0);
      end
      default: if (roll >= 90) it.cmd = 2'($urandom);
    endcase
    // occasional line glitch
    if ($urandom_range(0, 99) < 3) it.sda = ~it.sda;
    return it;
  endfunction

  function automatic bus_item_t mk_item(logic [1:0] cmd, logic [6:0] dev, logic [7:0] reg_a,
                                        logic [7:0] len, logic [7:0] wrb, logic sda);
    return {cmd, dev, reg_a, len, wrb, sda};
  endfunction

  // Typed result of an idle bus or a failed start: nothing else is active
  function automatic bus_res_t mk_res(logic scl, logic sda, logic done, logic [1:0] status);
    return {scl, sda, 8'h00, 1'b0, 1'b0, 1'b0, done, status};
  endfunction

  function automatic void add_row(bus_item_t item, logic typed, bus_res_t res);
    dir_tab.push_back({item, typed, res});
  endfunction

  // Offer one transaction, in bursts with random gaps, and predict its result
  task automatic send(input bus_item_t it, input logic typed, input bus_res_t tres);
    bus_res_t pr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i      <= it.cmd;
    dev_addr_i <= it.dev;
    reg_addr_i <= it.reg_a;
    length_i   <= it.len;
    wr_byte_i  <= it.wrb;
    sda_in_i   <= it.sda;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pr = bus_step(it);
    n_items++;
    if ((pr.busy || pr.done) && !pr.need) n_ticks++;
    if (pr.done) n_end[pr.status]++;
    if (pr.rd_valid) n_rd++;
    pending_res_q.push_back(typed ? tres : pr);
  endtask

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stall pattern: free-running, lightly and heavily stalled stretches
  always @(posedge clk_i) begin
    if (stall_cyc == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_cyc  = $urandom_range(20, 80);
    end else begin
      stall_cyc--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin
    bus_res_t got;
    bus_res_t want;
    got = {scl_out_o, sda_out_o, rd_byte_o, rd_valid_o, need_byte_o, busy_res_o, done_res_o,
           status_o};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_res_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("%0t: result with nothing pending", $realtime);
      end else begin
        want = pending_res_q.pop_front();
        n_checked++;
        if (got.scl !== want.scl || got.sda !== want.sda || got.rd_byte !== want.rd_byte ||
            got.rd_valid !== want.rd_valid || got.need !== want.need ||
            got.busy !== want.busy || got.done !== want.done ||
            got.status !== want.status) begin
          n_err++;
          if (n_err <= 10) begin
            $display("%0t: mismatch, want scl=%b sda=%b rd=%02h/%b need=%b busy=%b done=%b st=%0d",
                     $realtime, want.scl, want.sda, want.rd_byte, want.rd_valid, want.need,
                     want.busy, want.done, want.status);
            $display("%0t:             got scl=%b sda=%b rd=%02h/%b need=%b busy=%b done=%b st=%0d",
                     $realtime, got.scl, got.sda, got.rd_byte, got.rd_valid, got.need,
                     got.busy, got.done, got.status);
          end
        end
      end
    end
  end

  // Hard limit on run length
  initial begin
    #5ms;
    $display("i2c_master_register_access test failed");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    bus_item_t it;
    dir_row_t  row;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    cmd_i      <= CMD_TICK;
    dev_addr_i <= '0;
    reg_addr_i <= '0;
    length_i   <= '0;
    wr_byte_i  <= '0;
    sda_in_i   <= 1'b1;
    stall_cyc  = 0;
    stall_mode = 0;
    burst_left = 0;
    n_items    = 0;
    n_ticks    = 0;
    n_checked  = 0;
    n_err      = 0;
    n_rd       = 0;
    n_end      = '{0, 0, 0, 0};
    plan_nack_addr = 1'b0;
    bus_ph   = PH_IDLE;
    step     = '0;
    nbit     = '0;
    left_cnt = '0;
    shift_q  = '0;
    rd_mode  = 1'b0;
    tgt_addr = '0;
    tgt_reg  = '0;
    scl_q    = 1'b1;
    sda_q    = 1'b1;

    // idle bus, byte out of turn, bus busy and bus error at start, begin while busy
    add_row(mk_item(CMD_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1), 1'b1,
            mk_res(1'b1, 1'b1, 1'b0, ST_OK));
    add_row(mk_item(CMD_BYTE, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b0), 1'b1,
            mk_res(1'b1, 1'b1, 1'b0, ST_OK));
    add_row(mk_item(CMD_WRITE, 7'h7f, 8'hff, 8'hff, 8'h00, 1'b0), 1'b1,
            mk_res(1'b1, 1'b1, 1'b1, ST_BUS_BUSY));
    add_row(mk_item(CMD_READ, 7'h00, 8'h00, 8'h00, 8'hff, 1'b1), 1'b0, '0);
    add_row(mk_item(CMD_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1), 1'b1,
            mk_res(1'b1, 1'b0, 1'b1, ST_BUS_ERR));
    add_row(mk_item(CMD_READ, 7'h7f, 8'hff, 8'hff, 8'h00, 1'b0), 1'b1,
            mk_res(1'b1, 1'b1, 1'b1, ST_BUS_BUSY));
    add_row(mk_item(CMD_WRITE, 7'h2a, 8'h55, 8'h00, 8'ha5, 1'b1), 1'b0, '0);
    add_row(mk_item(CMD_READ, 7'h55, 8'haa, 8'hff, 8'h5a, 1'b0), 1'b0, '0);
    add_row(mk_item(CMD_WRITE, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1), 1'b0, '0);
    add_row(mk_item(CMD_BYTE, 7'h00, 8'h00, 8'h00, 8'hff, 1'b0), 1'b0, '0);
    add_row(mk_item(CMD_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1), 1'b0, '0);
    add_row(mk_item(CMD_READ, 7'h01, 8'h01, 8'h01, 8'h01, 1'b0), 1'b0, '0);
    add_row(mk_item(CMD_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1), 1'b0, '0);
    add_row(mk_item(CMD_WRITE, 7'h40, 8'h80, 8'h80, 8'h80, 1'b0), 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send(row.item, row.typed, row.res);
    end

    while (n_ticks < BUS_TICKS) begin
      it = pick_bus_item();
      send(it, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d transactions sent, %0d bus intervals; transfers ended ok %0d, busy %0d,",
             n_items, n_ticks, n_end[0], n_end[1]);
    $display("bus error %0d, no acknowledge %0d; %0d read bytes; %0d results checked",
             n_end[2], n_end[3], n_rd, n_checked);
    if (n_err == 0 && pending_res_q.size() == 0) begin
      $display("i2c_master_register_access test passed");
    end else begin
      $display("%0d mismatches", n_err);
      $display("i2c_master_register_access test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/i2cmra_pkg.sv
sv/i2c_master_register_access.sv
tb/tb_i2c_master_register_access.sv
